@@ hw/rtl/tbfe_pkg.sv @@
// tbfe_pkg: shared types, constants and the tap coefficient generator
// of the two-band equalizer. No dependencies.
`default_nettype none

package tbfe_pkg;

  typedef longint unsigned u64_t;

  localparam int GainW    = 7;
  localparam int CfgAddrW = 2;
  localparam int TapW     = 18;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] CfgVolume   = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgLowGain  = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgHighGain = 2'd2;

  localparam logic [GainW-1:0] GainReset = 7'd50;

  // output scaling: divide by 40960000 = 2^16 * 625, rounded half away from zero
  localparam int   OutShift = 16;
  localparam int   OutDiv   = 625;
  localparam u64_t OutHalf  = 64'd20480000;

  typedef struct packed {
    logic [GainW-1:0] vol;
    logic [GainW-1:0] low;
    logic [GainW-1:0] high;
  } gains_t;

  // fixed point used while evaluating the filter response
  localparam int   Frac   = 28;
  localparam u64_t DecOne = 64'd100000000000000000;

  function automatic longint round_shift(longint v, int k);
    u64_t half;
    u64_t m;
    half = 64'd1 << (k - 1);
    if (v >= 0) begin
      return $signed((u64_t'(v) + half) >> k);
    end
    m = 64'd0 - u64_t'(v);
    if (m <= half) begin
      return 0;
    end
    return -$signed((m - half + (64'd1 << k) - 64'd1) >> k);
  endfunction

  // decimal magnitude scaled by 1e17 to Q28, ties away from zero
  function automatic longint dec_to_fix(u64_t mag, bit neg);
    u64_t q;
    u64_t r;
    int   i;
    q = mag / DecOne;
    r = mag % DecOne;
    for (i = 0; i < Frac; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= DecOne) begin
        q = q | 64'd1;
        r = r - DecOne;
      end
    end
    if ((r << 1) >= DecOne) begin
      q = q + 64'd1;
    end
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic longint fmul(longint a, longint b);
    return round_shift(a * b, Frac);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // tap idx of the truncated impulse response of the two-biquad cascade, Q4.14
  function automatic logic signed [TapW-1:0] tap_coef(int idx);
    longint s;
    longint a21;
    longint b21;
    longint a31;
    longint a22;
    longint b22;
    longint a32;
    longint s2;
    longint v;
    longint hlim;
    longint num [5];
    longint den [5];
    longint resp [64];
    int     n;
    int     k;
    s    = dec_to_fix(64'd54115569484630355, 1'b0);
    a21  = dec_to_fix(64'd199290623303389880, 1'b1);
    b21  = dec_to_fix(64'd199955477951286960, 1'b1);
    a31  = dec_to_fix(64'd99295230173619742, 1'b0);
    a22  = dec_to_fix(64'd724203713206553, 1'b1);
    b22  = dec_to_fix(64'd199999999479703590, 1'b1);
    a32  = dec_to_fix(64'd31569379867829822, 1'b0);
    hlim = 64'sd8 << Frac;
    s2   = fmul(s, s);
    num[0] = s2;
    num[1] = fmul(s2, b21 + b22);
    num[2] = fmul(s2, (64'sd2 << Frac) + fmul(b21, b22));
    num[3] = num[1];
    num[4] = s2;
    den[0] = 0;
    den[1] = -(a21 + a22);
    den[2] = -(a32 + fmul(a21, a22) + a31);
    den[3] = -(fmul(a32, a21) + fmul(a22, a31));
    den[4] = -fmul(a32, a31);
    for (n = 0; n <= idx; n++) begin
      v = (n <= 4) ? num[n] : 0;
      for (k = 1; k <= 4; k++) begin
        if (k <= n) begin
          v = v + fmul(den[k], resp[n - k]);
        end
      end
      resp[n] = clamp(v, -hlim, hlim);
    end
    return TapW'(clamp(round_shift(resp[idx], Frac - 14),
                       -(64'sd1 << (TapW - 1)), (64'sd1 << (TapW - 1)) - 1));
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tbfe_tap_cell.sv @@
// tbfe_tap_cell: one cell of the transposed FIR chain, holding one partial sum.
// Depends on tbfe_pkg for the tap width.
`default_nettype none

module tbfe_tap_cell #(
  parameter int                                 SB    = 16,
  parameter int                                 ACC_W = 39,
  parameter logic signed [tbfe_pkg::TapW-1:0]   TAP   = '0
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en_i,
  input  wire logic                    restart_i,
  input  wire logic signed [SB-1:0]    x_i,
  input  wire logic signed [ACC_W-1:0] sum_i,
  output logic signed [ACC_W-1:0]      sum_o
);

  logic signed [tbfe_pkg::TapW+SB-1:0] prod;
  logic signed [ACC_W-1:0]             carry_in;
  logic signed [ACC_W-1:0]             sum_r;
  logic signed [ACC_W-1:0]             sum_nxt;

  always_comb begin
    prod     = TAP * x_i;
    // a new stream drops everything older than the current sample
    carry_in = restart_i ? {ACC_W{1'b0}} : sum_i;
    sum_nxt  = ACC_W'(prod) + carry_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (en_i) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum_o = sum_r;

endmodule

`default_nettype wire

@@ hw/rtl/tbfe_scale.sv @@
// tbfe_scale: band gains, master volume, rounding divide and saturation,
// five registered stages with per-stage valid. Depends on tbfe_pkg.
`default_nettype none

module tbfe_scale #(
  parameter int SB    = 16,
  parameter int ACC_W = 39
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire tbfe_pkg::gains_t        gains_i,
  input  wire logic                    valid_i,
  output logic                         ready_o,
  input  wire logic signed [ACC_W-1:0] acc_i,
  input  wire logic signed [SB-1:0]    x_i,
  input  wire logic                    last_i,
  output logic                         valid_o,
  input  wire logic                    ready_i,
  output logic [SB-1:0]                sample_o,
  output logic                         last_o
);

  localparam int MIX_W = ACC_W + 9;
  localparam int NUM_W = MIX_W + 8;
  localparam int T_W   = NUM_W + 1 - tbfe_pkg::OutShift;
  localparam int TN_W  = SB + 9;
  localparam int RCP_S = SB + 19;
  localparam int RCP_W = SB + 10;
  localparam int PROD_W = TN_W + RCP_W;
  localparam tbfe_pkg::u64_t RcpFull =
    ((64'd1 << RCP_S) + tbfe_pkg::OutDiv - 1) / tbfe_pkg::OutDiv;
  localparam logic [RCP_W-1:0] RcpM = RCP_W'(RcpFull);
  localparam logic [T_W-1:0]   SatT = T_W'(64'd625 << (SB - 1));
  localparam logic [SB-1:0]    SMax = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0]    SMin = {1'b1, {(SB-1){1'b0}}};

  // stage valids and readies
  logic v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy2, rdy3, rdy4, rdy5, rdy6;

  logic signed [MIX_W-1:0] mix_r, mix_nxt;
  logic signed [NUM_W-1:0] num_r, num_nxt;
  logic [T_W-1:0]          t_r, t_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic [SB-1:0]           out_r, out_nxt;
  logic                    last2_r, last3_r, last4_r, last5_r, last6_r;
  logic                    neg4_r, neg5_r, ovf5_r, ovf_nxt;

  logic signed [ACC_W+7:0] hi_prod;
  logic signed [SB+7:0]    lo_prod;
  logic [NUM_W-1:0]        mag;
  logic [NUM_W:0]          rsum;
  logic [SB-1:0]           qmag;

  assign rdy6    = !v6_r || ready_i;
  assign rdy5    = !v5_r || rdy6;
  assign rdy4    = !v4_r || rdy5;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || rdy3;
  assign ready_o = rdy2;

  always_comb begin
    hi_prod  = $signed({1'b0, gains_i.high}) * acc_i;
    lo_prod  = $signed({1'b0, gains_i.low}) * x_i;
    mix_nxt  = MIX_W'(hi_prod) + (MIX_W'(lo_prod) <<< 14);
    num_nxt  = $signed({1'b0, gains_i.vol}) * mix_r;
    mag      = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
    rsum     = {1'b0, mag} + (NUM_W+1)'(tbfe_pkg::OutHalf);
    t_nxt    = rsum[NUM_W:tbfe_pkg::OutShift];
    // quotient by 625 through an exact reciprocal over the unsaturated range
    ovf_nxt  = (t_r >= SatT);
    prod_nxt = PROD_W'(t_r[TN_W-1:0]) * PROD_W'(RcpM);
    qmag     = prod_r[PROD_W-1:RCP_S];
    if (ovf5_r) begin
      out_nxt = neg5_r ? SMin : SMax;
    end else begin
      out_nxt = neg5_r ? (~qmag + 1'b1) : qmag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= valid_i;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && valid_i) begin
      mix_r   <= mix_nxt;
      last2_r <= last_i;
    end
    if (rdy3 && v2_r) begin
      num_r   <= num_nxt;
      last3_r <= last2_r;
    end
    if (rdy4 && v3_r) begin
      t_r     <= t_nxt;
      neg4_r  <= num_r[NUM_W-1];
      last4_r <= last3_r;
    end
    if (rdy5 && v4_r) begin
      prod_r  <= prod_nxt;
      ovf5_r  <= ovf_nxt;
      neg5_r  <= neg4_r;
      last5_r <= last4_r;
    end
    if (rdy6 && v5_r) begin
      out_r   <= out_nxt;
      last6_r <= last5_r;
    end
  end

  assign valid_o  = v6_r;
  assign sample_o = out_r;
  assign last_o   = last6_r;

endmodule

`default_nettype wire

@@ hw/rtl/two_band_fir_equalizer.sv @@
// two_band_fir_equalizer: top level, configuration registers, the tap cell
// chain and the scaling pipeline. Depends on tbfe_pkg, tbfe_tap_cell, tbfe_scale.
//
// Usage: one signed audio sample per request on the in_ channel, one equalized
// sample per request on the out_ channel, in the same order. in_tuser set
// starts a new stream (all earlier history counts as zero); in_tlast is carried
// to out_tlast unchanged. The sum of the unfiltered band and a TAP_COUNT-tap FIR
// band is scaled by the volume and saturated to SAMPLE_BITS bits.
// Throughput: one request per cycle unless out_tready stalls the pipeline; the
// tap chain does one multiply-add per cell per sample and the scaling runs as a
// five-stage pipeline after the chain.
// Gains are written on the cfg_ port (0 volume, 1 low band, 2 high band); the user
// writes them only while no request is in flight, the block does not enforce it.
// Reset (rst_n low at a clock edge) clears the history, the pipeline and sets
// every gain to 50. When out_tready is low the result holds in the output
// register; in_tready stays high until the pipeline stages behind it fill.
`default_nettype none

module two_band_fir_equalizer #(
  parameter int TAP_COUNT   = 20,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,  // sample_in
  input  wire logic                                  in_tuser,  // start_of_stream
  input  wire logic                                  in_tlast,  // block_last_in
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]           out_tdata, // sample_out
  output logic                                       out_tlast, // block_last_out
  input  wire logic                                  cfg_we,
  input  wire logic [tbfe_pkg::CfgAddrW-1:0]         cfg_addr,
  input  wire logic [tbfe_pkg::GainW-1:0]            cfg_data
);

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int ACC_W  = SAMPLE_BITS + 18 + $clog2(TAP_COUNT);

  tbfe_pkg::gains_t gains_r;

  logic                          v1_r;
  logic                          last1_r;
  logic signed [SAMPLE_BITS-1:0] x1_r;
  logic signed [SAMPLE_BITS-1:0] x_in;
  logic                          rdy1;
  logic                          rdy2;
  logic                          accept;
  logic signed [ACC_W-1:0]       sums [TAP_COUNT+1];
  logic [SAMPLE_BITS-1:0]        sample_out;

  assign x_in      = $signed(in_tdata[SAMPLE_BITS-1:0]);
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign accept    = in_tvalid && rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.vol  <= tbfe_pkg::GainReset;
      gains_r.low  <= tbfe_pkg::GainReset;
      gains_r.high <= tbfe_pkg::GainReset;
    end else if (cfg_we) begin
      case (cfg_addr)
        tbfe_pkg::CfgVolume:   gains_r.vol  <= cfg_data;
        tbfe_pkg::CfgLowGain:  gains_r.low  <= cfg_data;
        tbfe_pkg::CfgHighGain: gains_r.high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1_r    <= x_in;
      last1_r <= in_tlast;
    end
  end

  // transposed FIR: cell k holds the partial sum handed on to cell k-1,
  // cell 0 holds the full convolution of the sample just taken
  assign sums[TAP_COUNT] = '0;

  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
    tbfe_tap_cell #(
      .SB    (SAMPLE_BITS),
      .ACC_W (ACC_W),
      .TAP   (tbfe_pkg::tap_coef(k))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en_i      (accept),
      .restart_i (in_tuser),
      .x_i       (x_in),
      .sum_i     (sums[k+1]),
      .sum_o     (sums[k])
    );
  end

  tbfe_scale #(
    .SB    (SAMPLE_BITS),
    .ACC_W (ACC_W)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .gains_i  (gains_r),
    .valid_i  (v1_r),
    .ready_o  (rdy2),
    .acc_i    (sums[0]),
    .x_i      (x1_r),
    .last_i   (last1_r),
    .valid_o  (out_tvalid),
    .ready_i  (out_tready),
    .sample_o (sample_out),
    .last_o   (out_tlast)
  );

  assign out_tdata = DATA_W'(sample_out);

endmodule

`default_nettype wire

@@ hw/rtl/tbfe_checker.sv @@
// tbfe_checker: port-level assertions for two_band_fir_equalizer and the bind
// that attaches them. Depends on the top level's port list.
`default_nettype none

module tbfe_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input wire logic                                  clk,
  input wire logic                                  rst_n,
  input wire logic                                  in_tvalid,
  input wire logic                                  in_tready,
  input wire logic                                  out_tvalid,
  input wire logic                                  out_tready,
  input wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      out_tdata,
  input wire logic                                  out_tlast
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // with nothing at the output every stage behind it has room
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked while output empty");

  // a request taken into an idle pipeline after reset cannot reach the output
  // on the next edge
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) && in_tvalid && in_tready |=> !out_tvalid)
    else $error("result appeared too early");

endmodule

bind two_band_fir_equalizer tbfe_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tbfe_checker (.*);

`default_nettype wire
